// ===== hdl/tpm_pkg.sv =====
// Shared types, constants and helpers for the true-peak meter.
// No dependencies; every other file of the block refers to this package by scoped names.
package tpm_pkg;

  // Default sizes, handed down from the top level.
  localparam int TAPS_DEF           = 49;
  localparam int SAMPLE_BITS_DEF    = 24;
  localparam int COEF_FRAC_BITS_DEF = 16;

  // Oversampling factor register and phase counter sizes.
  localparam int MAX_FACTOR = 4;
  localparam int FACTOR_W   = 3;
  localparam int PHASE_W    = 2;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 3'd4;

  // Configuration port geometry. Register index is paddr[2].
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_UPSAMPLE_FACTOR = 1'b0;

  // Gain constants for the sinc kernels, fixed point.
  localparam logic [63:0] TWO_OVER_PI_Q64 = 64'hA2F9836E4E44152A;
  localparam logic [63:0] SQRT2_Q62       = 64'h5A827999FCEF3242;
  localparam logic [63:0] SQRT3_Q62       = 64'h6ED9EBA16132A9CF;

  localparam logic [127:0] SQRT2_PROD = 128'(SQRT2_Q62) * 128'(TWO_OVER_PI_Q64);
  localparam logic [127:0] SQRT3_PROD = 128'(SQRT3_Q62) * 128'(TWO_OVER_PI_Q64);

  // Kernel gains as Q4.60: factor 2, factor 3, factor 4 even and odd distances.
  localparam logic [63:0] K2  = TWO_OVER_PI_Q64 >> 4;
  localparam logic [63:0] K3  = 64'(({2'b00, SQRT3_PROD[127:64]} * 66'd3) >> 4);
  localparam logic [63:0] K4E = TWO_OVER_PI_Q64 >> 3;
  localparam logic [63:0] K4O = SQRT2_PROD[127:64] >> 2;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_PEAK,
    ST_FINISH
  } tpm_state_t;

  // Control of one history cell.
  typedef struct packed {
    logic shift;
    logic rotate;
  } tpm_cell_ctl_t;

  // Control of the multiply-accumulate unit.
  typedef struct packed {
    logic                valid;
    logic                clear;
    logic [PHASE_W-1:0]  phase;
  } tpm_mac_ctl_t;

  // Register value to effective factor: zero acts as one, above four acts as four.
  function automatic logic [FACTOR_W-1:0] eff_factor(input logic [FACTOR_W-1:0] f);
    logic [FACTOR_W-1:0] r;
    if (f == '0) begin
      r = FACTOR_W'(1);
    end else if (f > FACTOR_W'(MAX_FACTOR)) begin
      r = FACTOR_W'(MAX_FACTOR);
    end else begin
      r = f;
    end
    return r;
  endfunction

endpackage

// ===== hdl/tpm_if.sv =====
// Valid/ready channel interfaces for the true-peak meter: sample input and peak output.
// Depends on tpm_pkg for default widths.
interface tpm_in_if #(
  parameter int SAMPLE_BITS = tpm_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface tpm_out_if #(
  parameter int SAMPLE_BITS = tpm_pkg::SAMPLE_BITS_DEF
);
  logic                     valid;
  logic                     ready;
  logic [SAMPLE_BITS+1:0]   true_peak;
  logic [SAMPLE_BITS-1:0]   sample_peak;

  modport source (output valid, output true_peak, output sample_peak, input ready);
  modport sink   (input valid, input true_peak, input sample_peak, output ready);
endinterface

// ===== hdl/tpm_cell.sv =====
// One cell of the history chain: holds one sample, shifts in from the newer side
// or rotates in from the older side. Depends on tpm_pkg for the control struct.
module tpm_cell #(
  parameter int W = tpm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  tpm_pkg::tpm_cell_ctl_t ctl,
  input  logic signed [W-1:0]   left,
  input  logic signed [W-1:0]   right,
  output logic signed [W-1:0]   q
);

  // A new word pushes every sample one place older; a rotation walks them back.
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (ctl.shift) begin
      q <= left;
    end else if (ctl.rotate) begin
      q <= right;
    end
  end

endmodule

// ===== hdl/tpm_coef_rom.sv =====
// Constant polyphase sinc coefficient tables, one per factor, in signed Q2.F format.
// Depends on tpm_pkg for the kernel gains; the tables are fixed at elaboration.
module tpm_coef_rom #(
  parameter int TAPS           = tpm_pkg::TAPS_DEF,
  parameter int COEF_FRAC_BITS = tpm_pkg::COEF_FRAC_BITS_DEF,
  localparam int CW            = COEF_FRAC_BITS + 2,
  localparam int IDX_W         = $clog2(TAPS)
) (
  input  logic [tpm_pkg::FACTOR_W-1:0] factor,
  input  logic [IDX_W-1:0]             index,
  output logic signed [CW-1:0]         coef
);

  localparam int HALF     = (TAPS - 1) / 2;
  localparam int SINC_LEN = 2 * HALF + 1;
  localparam int S        = 60 - COEF_FRAC_BITS;
  localparam logic [63:0] RND = 64'(1) << (S - 1);
  localparam logic [63:0] ONE = 64'(1) << COEF_FRAC_BITS;

  logic signed [CW-1:0] c1 [TAPS];
  logic signed [CW-1:0] c2 [TAPS];
  logic signed [CW-1:0] c3 [TAPS];
  logic signed [CW-1:0] c4 [TAPS];

  // Each entry j belongs to distance d = |HALF - j| from the centre tap.
  for (genvar j = 0; j < TAPS; j++) begin : g_tap
    localparam int D  = (j > HALF) ? (j - HALF) : (HALF - j);
    localparam int DS = (D == 0) ? 1 : D;
    localparam int R2 = D % 4;
    localparam int R3 = D % 6;
    localparam int R4 = D % 8;
    localparam logic [63:0] M2  = ((tpm_pkg::K2  / 64'(DS)) + RND) >> S;
    localparam logic [63:0] M3  = ((tpm_pkg::K3  / 64'(DS)) + RND) >> S;
    localparam logic [63:0] M4E = ((tpm_pkg::K4E / 64'(DS)) + RND) >> S;
    localparam logic [63:0] M4O = ((tpm_pkg::K4O / 64'(DS)) + RND) >> S;
    localparam bool_pad = 0;
    localparam logic [63:0] V1 = (j >= SINC_LEN) ? 64'd0 : (D == 0) ? ONE : 64'd0;
    localparam logic [63:0] V2 = (j >= SINC_LEN) ? 64'd0 : (D == 0) ? ONE :
                                 (R2 == 0 || R2 == 2) ? 64'd0 :
                                 (R2 == 3) ? -M2 : M2;
    localparam logic [63:0] V3 = (j >= SINC_LEN) ? 64'd0 : (D == 0) ? ONE :
                                 (R3 == 0 || R3 == 3) ? 64'd0 :
                                 (R3 > 3) ? -M3 : M3;
    localparam logic [63:0] M4 = (R4 == 2 || R4 == 6) ? M4E : M4O;
    localparam logic [63:0] V4 = (j >= SINC_LEN) ? 64'd0 : (D == 0) ? ONE :
                                 (R4 == 0 || R4 == 4) ? 64'd0 :
                                 (R4 > 4) ? -M4 : M4;
    assign c1[j] = CW'(V1 + 64'(bool_pad));
    assign c2[j] = CW'(V2);
    assign c3[j] = CW'(V3);
    assign c4[j] = CW'(V4);
  end

  // Table lookup for the active factor.
  always_comb begin
    case (factor)
      3'd2:    coef = c2[index];
      3'd3:    coef = c3[index];
      3'd4:    coef = c4[index];
      default: coef = c1[index];
    endcase
  end

endmodule

// ===== hdl/tpm_mac.sv =====
// Shared multiply-accumulate unit: operand register, product register and one
// accumulator per polyphase phase. Depends on tpm_pkg for the control struct.
module tpm_mac #(
  parameter int SAMPLE_BITS = tpm_pkg::SAMPLE_BITS_DEF,
  parameter int CW          = tpm_pkg::COEF_FRAC_BITS_DEF + 2,
  parameter int ACC_W       = SAMPLE_BITS + CW + 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  tpm_pkg::tpm_mac_ctl_t         ctl,
  input  logic signed [CW-1:0]          coef,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [tpm_pkg::PHASE_W-1:0]   rd_phase,
  output logic signed [ACC_W-1:0]       acc_rd
);

  localparam int PROD_W = SAMPLE_BITS + CW;

  logic                          v1;
  logic [tpm_pkg::PHASE_W-1:0]   ph1;
  logic signed [CW-1:0]          coef_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          v2;
  logic [tpm_pkg::PHASE_W-1:0]   ph2;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc [tpm_pkg::MAX_FACTOR];

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= ctl.valid;
      v2 <= v1;
    end
  end

  // Operand and product registers.
  always_ff @(posedge clk) begin
    ph1      <= ctl.phase;
    coef_q   <= coef;
    sample_q <= sample;
    ph2      <= ph1;
    prod     <= sample_q * coef_q;
  end

  // Phase accumulators, cleared when a new word enters.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      for (int i = 0; i < tpm_pkg::MAX_FACTOR; i++) begin
        acc[i] <= '0;
      end
    end else if (v2) begin
      acc[ph2] <= acc[ph2] + ACC_W'(prod);
    end
  end

  assign acc_rd = acc[rd_phase];

endmodule

// ===== hdl/true_peak_meter_top.sv =====
// True-peak meter: each word walks the coefficient table on the shared multiplier, with the
// history chain rotating between groups and rotation-only steps past the table end, then
// passes through the drain, peak and finish states back to idle. A new word is taken only in
// idle. The peak word is delayed while an earlier word still waits in the output register.
// Sync reset clears history, peaks, factor = 4.
module true_peak_meter_top #(
  parameter int TAPS           = tpm_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS    = tpm_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = tpm_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  tpm_in_if.sink                         audio,
  tpm_out_if.source                      peaks,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tpm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [tpm_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tpm_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);

  localparam int CW      = COEF_FRAC_BITS + 2;
  localparam int IDX_W   = $clog2(TAPS);
  localparam int ACC_W   = SAMPLE_BITS + CW + $clog2(TAPS);
  localparam int TP_W    = SAMPLE_BITS + 2;
  localparam int MAG_W   = ACC_W - COEF_FRAC_BITS + 1;
  localparam int TB_W    = $clog2(tpm_pkg::MAX_FACTOR * TAPS + tpm_pkg::MAX_FACTOR + 1);
  localparam int PHASE_W = tpm_pkg::PHASE_W;
  localparam int FW      = tpm_pkg::FACTOR_W;

  tpm_pkg::tpm_state_t state, state_next;

  logic [FW-1:0]                factor;
  logic [FW-1:0]                fe;
  logic [PHASE_W-1:0]           fe_last;
  logic [IDX_W-1:0]             k, k_next;
  logic [PHASE_W-1:0]           p, p_next;
  logic [TB_W-1:0]              tbase, tbase_next;
  logic [TB_W-1:0]              t;
  logic                         drain, drain_next;
  logic                         mac_valid;
  logic                         rot;
  logic                         accept;
  logic                         rotate;
  logic                         finish;
  logic [IDX_W-1:0]             rom_index;
  logic signed [CW-1:0]         coef;
  logic signed [SAMPLE_BITS-1:0] raw_x;
  logic [SAMPLE_BITS-1:0]       abs_raw;
  logic [TP_W-1:0]              tp_work, tp_work_next;
  logic [TP_W-1:0]              tp_hold;
  logic [SAMPLE_BITS-1:0]       sp_hold;
  logic [TP_W-1:0]              tp_final;
  logic [SAMPLE_BITS-1:0]       sp_final;
  logic signed [ACC_W-1:0]      acc_rd;
  logic [ACC_W-1:0]             acc_abs;
  logic [ACC_W:0]               rnd_sum;
  logic [MAG_W-1:0]             mag;
  logic [TP_W-1:0]              mag_sat;
  logic                         out_valid;
  logic [TP_W-1:0]              out_tp;
  logic [SAMPLE_BITS-1:0]       out_sp;
  logic signed [SAMPLE_BITS-1:0] hist [TAPS];

  tpm_pkg::tpm_cell_ctl_t cell_ctl;
  tpm_pkg::tpm_mac_ctl_t  mac_ctl;

  // Configuration register: the oversampling factor.
  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= tpm_pkg::FACTOR_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == tpm_pkg::REG_UPSAMPLE_FACTOR)) begin
      factor <= pwdata[FW-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == tpm_pkg::REG_UPSAMPLE_FACTOR) ?
                  {{(tpm_pkg::APB_DATA_W - FW){1'b0}}, factor} : '0;

  assign fe      = tpm_pkg::eff_factor(factor);
  assign fe_last = PHASE_W'(fe - FW'(1));

  // Coefficient index walks p + k*F; entries past the table end are skipped.
  assign t         = tbase + TB_W'(p);
  assign mac_valid = (state == tpm_pkg::ST_RUN) && (t < TB_W'(TAPS));
  assign rot       = !mac_valid || (p == fe_last);
  assign rom_index = mac_valid ? t[IDX_W-1:0] : '0;

  assign audio.ready = (state == tpm_pkg::ST_IDLE);

  // History chain. Cell 0 holds the sample the MAC sees during the walk.
  assign cell_ctl.shift  = accept;
  assign cell_ctl.rotate = rotate;

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    if (i == 0) begin : g_head
      assign left = audio.sample;
    end else begin : g_mid_l
      assign left = hist[i-1];
    end
    if (i == TAPS - 1) begin : g_tail
      assign right = hist[0];
    end else begin : g_mid_r
      assign right = hist[i+1];
    end
    tpm_cell #(.W(SAMPLE_BITS)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (cell_ctl),
      .left  (left),
      .right (right),
      .q     (hist[i])
    );
  end

  tpm_coef_rom #(
    .TAPS           (TAPS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_rom (
    .factor (fe),
    .index  (rom_index),
    .coef   (coef)
  );

  assign mac_ctl.valid = mac_valid;
  assign mac_ctl.clear = accept;
  assign mac_ctl.phase = p;

  tpm_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .CW          (CW),
    .ACC_W       (ACC_W)
  ) u_mac (
    .clk      (clk),
    .rst      (rst),
    .ctl      (mac_ctl),
    .coef     (coef),
    .sample   (hist[0]),
    .rd_phase (p),
    .acc_rd   (acc_rd)
  );

  // Rounded, saturated magnitude of the phase accumulator being inspected.
  always_comb begin
    acc_abs = acc_rd[ACC_W-1] ? ACC_W'(-acc_rd) : ACC_W'(acc_rd);
    rnd_sum = {1'b0, acc_abs} + ((ACC_W + 1)'(1) << (COEF_FRAC_BITS - 1));
    mag     = rnd_sum[ACC_W:COEF_FRAC_BITS];
    mag_sat = (|mag[MAG_W-1:TP_W]) ? {TP_W{1'b1}} : mag[TP_W-1:0];
  end

  // Raw sample magnitude and the final peak values.
  always_comb begin
    abs_raw  = raw_x[SAMPLE_BITS-1] ? (~raw_x + 1'b1) : raw_x;
    tp_final = ({2'b00, abs_raw} > tp_work) ? {2'b00, abs_raw} : tp_work;
    sp_final = (abs_raw > sp_hold) ? abs_raw : sp_hold;
  end

  // Sequencer: next state and strobes.
  always_comb begin
    state_next   = state;
    k_next       = k;
    p_next       = p;
    tbase_next   = tbase;
    drain_next   = drain;
    tp_work_next = tp_work;
    accept       = 1'b0;
    rotate       = 1'b0;
    finish       = 1'b0;
    case (state)
      tpm_pkg::ST_IDLE: begin
        if (audio.valid) begin
          accept       = 1'b1;
          state_next   = tpm_pkg::ST_RUN;
          k_next       = '0;
          p_next       = '0;
          tbase_next   = '0;
          tp_work_next = tp_hold;
        end
      end
      tpm_pkg::ST_RUN: begin
        if (rot) begin
          rotate     = 1'b1;
          p_next     = '0;
          tbase_next = tbase + TB_W'(fe);
          if (k == IDX_W'(TAPS - 1)) begin
            state_next = tpm_pkg::ST_DRAIN;
            drain_next = 1'b0;
          end else begin
            k_next = k + 1'b1;
          end
        end else begin
          p_next = p + 1'b1;
        end
      end
      tpm_pkg::ST_DRAIN: begin
        if (drain) begin
          state_next = tpm_pkg::ST_PEAK;
          p_next     = '0;
        end else begin
          drain_next = 1'b1;
        end
      end
      tpm_pkg::ST_PEAK: begin
        if (mag_sat > tp_work) begin
          tp_work_next = mag_sat;
        end
        if (p == fe_last) begin
          state_next = tpm_pkg::ST_FINISH;
        end else begin
          p_next = p + 1'b1;
        end
      end
      tpm_pkg::ST_FINISH: begin
        if (!out_valid || peaks.ready) begin
          finish     = 1'b1;
          state_next = tpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tpm_pkg::ST_IDLE;
      end
    endcase
  end

  // State and peak holds.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= tpm_pkg::ST_IDLE;
      drain   <= 1'b0;
      tp_hold <= '0;
      sp_hold <= '0;
    end else begin
      state <= state_next;
      drain <= drain_next;
      if (finish) begin
        tp_hold <= tp_final;
        sp_hold <= sp_final;
      end
    end
  end

  // Walk counters and working registers.
  always_ff @(posedge clk) begin
    k       <= k_next;
    p       <= p_next;
    tbase   <= tbase_next;
    tp_work <= tp_work_next;
    if (accept) begin
      raw_x <= audio.sample;
    end
  end

  // Output register: the finished word waits here while the next one is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (peaks.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_tp <= tp_final;
      out_sp <= sp_final;
    end
  end

  assign peaks.valid       = out_valid;
  assign peaks.true_peak   = out_tp;
  assign peaks.sample_peak = out_sp;

endmodule

// ===== hdl/tpm_checker.sv =====
// Port-level checks for the true-peak meter, attached to the top level by bind.
// Depends only on the top level's ports and tpm_pkg defaults.
module tpm_checker #(
  parameter int SAMPLE_BITS = tpm_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS+1:0] true_peak,
  input logic [SAMPLE_BITS-1:0] sample_peak
);

  logic [SAMPLE_BITS-1:0] last_sp;

  // Sample peak of the last delivered word.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_sp <= '0;
    end else if (out_valid && out_ready) begin
      last_sp <= sample_peak;
    end
  end

  // A waiting word stays put until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(true_peak) && $stable(sample_peak))
    else $error("output word changed while stalled");

  // The true peak always covers the raw sample peak.
  a_tp_covers_sp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> true_peak >= {2'b00, sample_peak})
    else $error("true peak below sample peak");

  // The sample peak only grows between delivered words.
  a_sp_monotone: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |-> sample_peak >= last_sp)
    else $error("sample peak decreased");

  // One word at a time: the input closes right after a word is taken.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in progress");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind true_peak_meter_top tpm_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_tpm_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (audio.valid),
  .in_ready    (audio.ready),
  .out_valid   (peaks.valid),
  .out_ready   (peaks.ready),
  .true_peak   (peaks.true_peak),
  .sample_peak (peaks.sample_peak)
);

// ===== tb/tb_true_peak_meter_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for true_peak_meter_top: audio words in, peak words out, with an
// in-bench polyphase sinc predictor, random gaps and stalls, and factor register phases.
// Depends on tpm_pkg, the tpm_in_if / tpm_out_if interfaces and the meter RTL.
module tb_true_peak_meter_top;

  localparam int SAMPLE_BITS    = tpm_pkg::SAMPLE_BITS_DEF;
  localparam int TAPS           = tpm_pkg::TAPS_DEF;
  localparam int COEF_FRAC_BITS = tpm_pkg::COEF_FRAC_BITS_DEF;
  localparam int DATA_W         = tpm_pkg::APB_DATA_W;
  localparam int FACTOR_W       = tpm_pkg::FACTOR_W;
  localparam int PEAK_W         = SAMPLE_BITS + 2;
  localparam int HALF_TAPS      = (TAPS - 1) / 2;
  localparam int SINC_LEN       = 2 * HALF_TAPS + 1;
  localparam int GAIN_SHIFT     = 60 - COEF_FRAC_BITS;
  localparam longint unsigned PEAK_MAX = (64'd1 << PEAK_W) - 1;
  localparam int SAMPLE_MAX     = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int SAMPLE_MIN     = -(1 << (SAMPLE_BITS - 1));

  localparam int PHASE_COUNT    = 10;
  localparam int PHASE_ITEMS    = 85;
  localparam int RANDOM_ITEMS   = PHASE_COUNT * PHASE_ITEMS;
  localparam int PRESSURE_AT    = 320;
  localparam int PRESSURE_LEN   = 1000;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 200;
  localparam int MAX_PRINTED    = 100;

  localparam logic [tpm_pkg::APB_ADDR_W-1:0] FACTOR_ADDR =
    {tpm_pkg::REG_UPSAMPLE_FACTOR, 2'b00};

  // Kernel gain inputs: 2/pi as Q0.64, sqrt2 and sqrt3 as Q2.62.
  localparam logic [63:0] TWO_PI_INV = 64'hA2F9836E4E44152A;
  localparam logic [63:0] ROOT2_Q62  = 64'h5A827999FCEF3242;
  localparam logic [63:0] ROOT3_Q62  = 64'h6ED9EBA16132A9CF;

  typedef struct packed {
    logic [PEAK_W-1:0]      true_peak;
    logic [SAMPLE_BITS-1:0] sample_peak;
  } peak_word_t;

  logic                           clk;
  logic                           rst;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [tpm_pkg::APB_ADDR_W-1:0] paddr;
  logic [DATA_W-1:0]              pwdata;
  logic [DATA_W-1:0]              prdata;
  logic                           pready;

  tpm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) audio_ch ();
  tpm_out_if #(.SAMPLE_BITS(SAMPLE_BITS)) peak_ch ();

  true_peak_meter_top #(
    .TAPS           (TAPS),
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .audio   (audio_ch.sink),
    .peaks   (peak_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state: coefficient tables per factor, history line, peak holds.
  longint                  sinc_rom [1:4][TAPS];
  longint                  hist_line [TAPS];
  longint unsigned         tp_hold;
  longint unsigned         sp_hold;
  logic [FACTOR_W-1:0]     factor_reg;
  peak_word_t              peak_expect_q [$];

  // Stimulus and flow control.
  logic signed [SAMPLE_BITS-1:0] audio_pending_q [$];
  int samples_queued = 0;
  int samples_taken  = 0;
  int words_seen     = 0;
  int error_count    = 0;
  int quiet_cycles   = 0;
  int gap_left       = 0;
  int hold_left      = 0;
  int stall_pick     = 0;
  bit steady_flow    = 1'b0;
  bit pressure_done  = 1'b0;
  bit audio_fire     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    if (error_count < MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Register value to the factor actually used: zero runs as one, above four as four.
  function automatic int factor_in_use(input logic [FACTOR_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > tpm_pkg::MAX_FACTOR) return tpm_pkg::MAX_FACTOR;
    return int'(raw);
  endfunction

  // Signed Q2.16 sinc coefficient for factor f at table entry j, magnitude rounded half up.
  function automatic longint sinc_tap(input int f, input int j);
    logic [127:0]    prod;
    logic [63:0]     gain;
    longint unsigned tap_dist;
    longint unsigned mag;
    int              r;
    bit              neg;
    bit              zero;
    if (j >= SINC_LEN) return 0;
    tap_dist = (j > HALF_TAPS) ? j - HALF_TAPS : HALF_TAPS - j;
    if (tap_dist == 0) return longint'(1) << COEF_FRAC_BITS;
    zero = 1'b0;
    neg  = 1'b0;
    gain = '0;
    case (f)
      2: begin
        r    = int'(tap_dist % 4);
        zero = (r == 0 || r == 2);
        gain = TWO_PI_INV >> 4;
        neg  = (r == 3);
      end
      3: begin
        r    = int'(tap_dist % 6);
        zero = (r == 0 || r == 3);
        prod = 128'(ROOT3_Q62) * 128'(TWO_PI_INV);
        gain = (prod[127:64] * 64'd3) >> 4;
        neg  = (r > 3);
      end
      4: begin
        r    = int'(tap_dist % 8);
        zero = (r == 0 || r == 4);
        prod = 128'(ROOT2_Q62) * 128'(TWO_PI_INV);
        gain = (r == 2 || r == 6) ? (TWO_PI_INV >> 3) : (prod[127:64] >> 2);
        neg  = (r > 4);
      end
      default: begin
        // With no oversampling only the centre tap carries weight.
        zero = 1'b1;
      end
    endcase
    if (zero) return 0;
    mag = ((gain / tap_dist) + (64'd1 << (GAIN_SHIFT - 1))) >> GAIN_SHIFT;
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  // Shift one word into the history, run every phase and update both peak holds.
  task automatic predict_peaks(input logic signed [SAMPLE_BITS-1:0] smp);
    longint          acc;
    longint          x;
    longint unsigned mag;
    longint unsigned absx;
    longint unsigned tp;
    int              f;
    int              p;
    int              k;
    peak_word_t      w;
    f = factor_in_use(factor_reg);
    x = smp;
    for (k = TAPS - 1; k > 0; k--) hist_line[k] = hist_line[k-1];
    hist_line[0] = x;
    tp = tp_hold;
    for (p = 0; p < f; p++) begin
      acc = 0;
      for (k = 0; p + k * f < TAPS; k++) acc += sinc_rom[f][p + k * f] * hist_line[k];
      mag = (acc < 0) ? -acc : acc;
      mag = (mag + (64'd1 << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
      if (mag > PEAK_MAX) mag = PEAK_MAX;
      if (mag > tp) tp = mag;
    end
    absx = (x < 0) ? -x : x;
    if (absx > tp) tp = (absx > PEAK_MAX) ? PEAK_MAX : absx;
    if (absx > sp_hold) sp_hold = absx;
    tp_hold = tp;
    w.true_peak   = PEAK_W'(tp_hold);
    w.sample_peak = SAMPLE_BITS'(sp_hold);
    peak_expect_q.insert(peak_expect_q.size(), w);
  endtask

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Audio driver: presents the next pending word at the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      audio_ch.valid <= 1'b0;
      audio_ch.sample <= '0;
      gap_left <= 0;
    end else if (!audio_ch.valid || audio_fire) begin
      if (gap_left > 0) begin
        audio_ch.valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (audio_pending_q.size() != 0) begin
        audio_ch.valid <= 1'b1;
        audio_ch.sample <= audio_pending_q.pop_front();
        gap_left <= draw_gap();
      end else begin
        audio_ch.valid <= 1'b0;
      end
    end
  end

  // Peak receiver: random stalls, one long hold-off to back the block up.
  always @(negedge clk) begin
    if (rst) begin
      peak_ch.ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      peak_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!pressure_done && words_seen >= PRESSURE_AT) begin
      peak_ch.ready <= 1'b0;
      hold_left <= PRESSURE_LEN;
      pressure_done <= 1'b1;
    end else if (steady_flow) begin
      peak_ch.ready <= 1'b1;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 70) begin
        peak_ch.ready <= 1'b1;
      end else if (stall_pick < 96) begin
        peak_ch.ready <= 1'b0;
        hold_left <= $urandom_range(0, 3);
      end else begin
        peak_ch.ready <= 1'b0;
        hold_left <= $urandom_range(20, 150);
      end
    end
  end

  // Monitor: checks each peak word, predicts each accepted audio word, runs the watchdog.
  always @(posedge clk) begin
    peak_word_t want;
    audio_fire <= audio_ch.valid && audio_ch.ready;
    if (!rst) begin
      if (peak_ch.valid && peak_ch.ready) begin
        words_seen++;
        if (peak_expect_q.size() == 0) begin
          flag_error($sformatf("peak word with none expected: true_peak=%0d sample_peak=%0d",
                               peak_ch.true_peak, peak_ch.sample_peak));
        end else begin
          want = peak_expect_q.pop_front();
          if (peak_ch.true_peak !== want.true_peak)
            flag_error($sformatf("word %0d true_peak=%0d, predicted %0d",
                                 words_seen, peak_ch.true_peak, want.true_peak));
          if (peak_ch.sample_peak !== want.sample_peak)
            flag_error($sformatf("word %0d sample_peak=%0d, predicted %0d",
                                 words_seen, peak_ch.sample_peak, want.sample_peak));
        end
      end
      if (audio_ch.valid && audio_ch.ready) begin
        predict_peaks(audio_ch.sample);
        samples_taken++;
      end
      if ((audio_ch.valid && audio_ch.ready) || (peak_ch.valid && peak_ch.ready) ||
          (psel && penable && pready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("true_peak_meter_top verification failed");
        $finish;
      end
    end
  end

  task automatic queue_sample(input int value);
    audio_pending_q.insert(audio_pending_q.size(), SAMPLE_BITS'(value));
    samples_queued++;
  endtask

  // Loop until every queued word has been taken and every peak word has come back.
  task automatic wait_drained();
    while (audio_pending_q.size() != 0 || samples_taken != samples_queued ||
           peak_expect_q.size() != 0)
      @(posedge clk);
  endtask

  // One APB transfer to the factor register: setup cycle, then access until pready.
  task automatic apb_access(input bit wr, input logic [DATA_W-1:0] wdata,
                            output logic [DATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= FACTOR_ADDR;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_factor(input logic [FACTOR_W-1:0] value);
    logic [DATA_W-1:0] readback;
    apb_access(1'b0, '0, readback);
    if (readback !== DATA_W'(value))
      flag_error($sformatf("upsample_factor read %0d, written %0d", readback, value));
  endtask

  // Upper data bits are random; only the low three bits belong to the register.
  task automatic set_factor(input logic [FACTOR_W-1:0] value);
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] unused;
    wait_drained();
    wdata = $urandom();
    wdata[FACTOR_W-1:0] = value;
    apb_access(1'b1, wdata, unused);
    factor_reg = value;
    check_factor(value);
  endtask

  // Signs follow one phase's coefficients so the interpolated value overshoots the raw peak.
  task automatic queue_overshoot(input int amp);
    int f;
    int p;
    int k;
    int mag;
    int phase_taps;
    bit flip;
    f = factor_in_use(factor_reg);
    p = $urandom_range(0, f - 1);
    flip = $urandom_range(0, 1);
    phase_taps = (TAPS - p + f - 1) / f;
    for (k = phase_taps - 1; k >= 0; k--) begin
      if (sinc_rom[f][p + k * f] == 0) begin
        mag = $urandom_range(0, amp / 8);
        if ($urandom_range(0, 1)) mag = -mag;
      end else begin
        mag = $urandom_range(amp / 2, amp);
        if ((sinc_rom[f][p + k * f] < 0) != flip) mag = -mag;
      end
      queue_sample(mag);
    end
  endtask

  task automatic queue_noise(input int amp);
    int n;
    n = $urandom_range(1, 8);
    repeat (n) queue_sample(int'($urandom_range(0, 2 * amp)) - amp);
  endtask

  task automatic queue_impulse(input int amp);
    int mag;
    mag = $urandom_range(amp / 2, amp);
    queue_sample($urandom_range(0, 1) ? mag : -mag);
    repeat ($urandom_range(0, 10)) queue_sample(0);
  endtask

  initial begin
    int opening [14] = '{0, 1, -1, 0, 5, -7, 1000, 0, 0, 0, 0, 0, -3000, 2};
    int phase_factor [PHASE_COUNT] = '{1, 0, 2, 3, 7, 5, 6, -1, -1, 4};
    int phase_end;
    int amp_bits;
    int kind;
    int f;
    logic [FACTOR_W-1:0] next_factor;

    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;

    for (f = 1; f <= 4; f++)
      for (int j = 0; j < TAPS; j++) sinc_rom[f][j] = sinc_tap(f, j);
    foreach (hist_line[k]) hist_line[k] = 0;
    tp_hold    = 0;
    sp_hold    = 0;
    factor_reg = tpm_pkg::FACTOR_RESET;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset value of the factor, then small words so the peaks keep room to grow.
    check_factor(tpm_pkg::FACTOR_RESET);
    foreach (opening[i]) queue_sample(opening[i]);

    // Random phases, each under its own factor; amplitude grows across the run
    // since both peaks only ever rise.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      next_factor = (phase_factor[ph] < 0) ? FACTOR_W'($urandom_range(0, 7))
                                            : FACTOR_W'(phase_factor[ph]);
      set_factor(next_factor);
      steady_flow = (ph % 4 == 3);
      phase_end = samples_queued + PHASE_ITEMS;
      while (samples_queued < phase_end) begin
        amp_bits = 3 + ((ph * PHASE_ITEMS + PHASE_ITEMS - (phase_end - samples_queued)) * 20)
                   / RANDOM_ITEMS;
        if (amp_bits > SAMPLE_BITS - 1) amp_bits = SAMPLE_BITS - 1;
        kind = $urandom_range(0, 99);
        if (kind < 60) queue_overshoot((1 << amp_bits) - 1);
        else if (kind < 85) queue_noise((1 << amp_bits) - 1);
        else queue_impulse((1 << amp_bits) - 1);
      end
    end

    // Full-scale extremes come last, since they pin both peaks for good.
    steady_flow = 1'b0;
    queue_sample(SAMPLE_MAX);
    queue_sample(SAMPLE_MIN);
    queue_overshoot(SAMPLE_MAX);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("true_peak_meter_top verification clean");
    else
      $display("true_peak_meter_top verification failed");
    $finish;
  end

endmodule
